FILE: rtl/assert_macros.svh
// Assertion helpers; the module using them must have clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define FCFB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fcfb: assertion failed");

// condition never true outside reset
`define FCFB_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("fcfb: forbidden condition seen");

`endif

FILE: rtl/fcfb_pkg.sv
`default_nettype none

package fcfb_pkg;

	localparam int COLOR_W       = 32;
	localparam int CH_W          = 8;
	localparam int NUM_CH        = 4;
	localparam int DEPTH_W       = 24;
	localparam int DIST_W        = 24;
	localparam int FOG_FRAC_BITS = 8;
	localparam int FOG_W         = FOG_FRAC_BITS + 1;
	localparam int DIFF_W        = DIST_W + 1;
	// |far - near| of two DIST_W signed values fits DIST_W unsigned bits
	localparam int MAG_W         = DIST_W;
	localparam int DIV_STAGES    = FOG_FRAC_BITS;

	localparam int EN_W          = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 24;

	localparam int FQ_DEPTH      = 4;
	localparam int FQ_PTR_W      = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W      = $clog2(FQ_DEPTH + 1);
	localparam int OQ_DEPTH      = 16;
	localparam int OQ_PTR_W      = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W      = $clog2(OQ_DEPTH + 1);

	localparam int EN_BLEND      = 0;
	localparam int EN_ALPHA      = 1;
	localparam int EN_DEPTH      = 2;
	localparam int EN_FOG        = 3;
	localparam int EN_ZWRITE     = 4;

	localparam logic [CH_W-1:0]    CH_MAX      = '1;
	localparam logic [FOG_W-1:0]   FOG_ONE     = FOG_W'(2 ** FOG_FRAC_BITS);
	localparam logic [DIST_W-1:0]  FOG_END_RST = DIST_W'(256);

	// x / 255 as multiply by ceil(2^23 / 255), then one correction step
	localparam int               RECIP_W     = 16;
	localparam int               RECIP_SHIFT = 23;
	localparam logic [RECIP_W-1:0] RECIP_255 = 16'h8081;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLES,
		CFG_DEPTH_MODE,
		CFG_COMBINE_OPS,
		CFG_BLEND_MODES,
		CFG_ALPHA_REF,
		CFG_FOG_RGB,
		CFG_FOG_START,
		CFG_FOG_END
	} cfg_index_t;

	typedef enum logic [1:0] {
		COMB_VERTEX,
		COMB_MODULATE,
		COMB_ADD,
		COMB_TEXEL
	} comb_op_t;

	typedef enum logic [1:0] {
		DST_INV_ALPHA,
		DST_ONE,
		DST_ZERO,
		DST_UNUSED
	} dst_factor_t;

	typedef enum logic [1:0] {
		FOGF_ZERO,
		FOGF_ONE,
		FOGF_DIV
	} fog_kind_t;

	typedef struct packed {
		logic [EN_W-1:0]          enables;
		logic                     depth_mode;
		logic [3:0]               combine_ops;
		logic [2:0]               blend_modes;
		logic [CH_W-1:0]          alpha_reference;
		logic [3*CH_W-1:0]        fog_rgb;
		logic signed [DIST_W-1:0] fog_start;
		logic signed [DIST_W-1:0] fog_end;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0]       vertex_color;
		logic [COLOR_W-1:0]       texel_color;
		logic                     use_texture;
		logic                     apply_fog;
		logic signed [DIST_W-1:0] fog_distance;
		logic [DEPTH_W-1:0]       frag_depth;
		logic [COLOR_W-1:0]       stored_color;
		logic [DEPTH_W-1:0]       stored_depth;
	} frag_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color_out;
		logic               color_write;
		logic [DEPTH_W-1:0] depth_out;
		logic               depth_write;
	} result_t;

	// classified item between front and back
	typedef struct packed {
		logic [COLOR_W-1:0]             vertex_color;
		logic [COLOR_W-1:0]             texel_color;
		logic [NUM_CH-1:0][2*CH_W-1:0]  prod;
		logic                           use_texture;
		logic                           fog_on;
		fog_kind_t                      fog_kind;
		logic [MAG_W-1:0]               fog_num;
		logic [MAG_W-1:0]               fog_den;
		logic                           depth_pass;
		logic [DEPTH_W-1:0]             frag_depth;
		logic [COLOR_W-1:0]             stored_color;
	} entry_t;

	function automatic logic [CH_W:0] div255(input logic [2*CH_W:0] x);
		logic [2*CH_W+RECIP_W:0] m;
		logic [CH_W:0]           q;
		logic [2*CH_W:0]         qm;
		m  = (2*CH_W+RECIP_W+1)'(x) * (2*CH_W+RECIP_W+1)'(RECIP_255);
		q  = m[RECIP_SHIFT +: CH_W+1];
		qm = {q, {CH_W{1'b0}}} - (2*CH_W+1)'(q);
		// estimate is never low and at most one high
		if (qm > x) begin
			q = q - 1'b1;
		end
		return q;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/fragment_combine_test_fog_blend_unit.sv
// Fragment back end: depth test, texture combine, alpha test, linear fog
// and alpha blend for one fragment per item.
// Input channel: push/full with the frag struct; an item is taken at a clock
// edge with push high and full low. Result channel: empty/pop with the
// result struct; the oldest result is shown while empty is low and leaves
// at an edge with pop high.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no item is in flight.
// Throughput: one item per clock while the receiver keeps popping results.
// After it is taken, an item passes the fog factor divider (one quotient bit
// per stage, 8 stages), the fog result register and the blend product
// register, then final scaling on its way into the result queue.
// A 4-entry queue between front and back and a 16-entry result queue let
// each side stall on its own; the back issues only with a free result slot.
// If the receiver stops popping, the result queue fills, the back stops,
// the front queue fills and full rises; nothing is dropped.
// Reset empties both queues and loads the register reset values
// (fog_end 256, all others zero).
`default_nettype none

module fragment_combine_test_fog_blend_unit import fcfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  frag_t                 frag,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result
);

	cfg_t   cfg_q;
	logic   take;
	logic   head_valid;
	entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enables         <= '0;
			cfg_q.depth_mode      <= 1'b0;
			cfg_q.combine_ops     <= '0;
			cfg_q.blend_modes     <= '0;
			cfg_q.alpha_reference <= '0;
			cfg_q.fog_rgb         <= '0;
			cfg_q.fog_start       <= '0;
			cfg_q.fog_end         <= FOG_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ENABLES:     cfg_q.enables         <= cfg_data[EN_W-1:0];
				CFG_DEPTH_MODE:  cfg_q.depth_mode      <= cfg_data[0];
				CFG_COMBINE_OPS: cfg_q.combine_ops     <= cfg_data[3:0];
				CFG_BLEND_MODES: cfg_q.blend_modes     <= cfg_data[2:0];
				CFG_ALPHA_REF:   cfg_q.alpha_reference <= cfg_data[CH_W-1:0];
				CFG_FOG_RGB:     cfg_q.fog_rgb         <= cfg_data[3*CH_W-1:0];
				CFG_FOG_START:   cfg_q.fog_start       <= cfg_data[DIST_W-1:0];
				CFG_FOG_END:     cfg_q.fog_end         <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	fcfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.frag       (frag),
		.take       (take),
		.head_valid (head_valid),
		.head       (head)
	);

	fcfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.take       (take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire

FILE: rtl/fcfb_front.sv
`default_nettype none
`include "assert_macros.svh"

module fcfb_front import fcfb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   push,
	output logic   full,
	input  frag_t  frag,
	input  logic   take,
	output logic   head_valid,
	output entry_t head
);

	entry_t                 ent_d;
	entry_t                 mem_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0]    wr_ptr_q;
	logic [FQ_PTR_W-1:0]    rd_ptr_q;
	logic [FQ_CNT_W-1:0]    cnt_q;
	logic                   wr_en;

	logic signed [DIFF_W-1:0] far_x;
	logic signed [DIFF_W-1:0] near_x;
	logic signed [DIFF_W-1:0] dist_x;
	logic signed [DIFF_W-1:0] num;
	logic signed [DIFF_W-1:0] den;
	logic signed [DIFF_W-1:0] num_n;
	logic signed [DIFF_W-1:0] den_n;
	logic [NUM_CH-1:0][CH_W-1:0] vc;
	logic [NUM_CH-1:0][CH_W-1:0] tc;

	always_comb begin
		far_x  = {cfg.fog_end[DIST_W-1], cfg.fog_end};
		near_x = {cfg.fog_start[DIST_W-1], cfg.fog_start};
		dist_x = {frag.fog_distance[DIST_W-1], frag.fog_distance};
		num    = far_x - dist_x;
		den    = far_x - near_x;
		num_n  = den[DIFF_W-1] ? -num : num;
		den_n  = den[DIFF_W-1] ? -den : den;
		vc     = frag.vertex_color;
		tc     = frag.texel_color;

		ent_d.vertex_color = frag.vertex_color;
		ent_d.texel_color  = frag.texel_color;
		for (int i = 0; i < NUM_CH; i++) begin
			ent_d.prod[i] = (2*CH_W)'(vc[i] * tc[i]);
		end
		ent_d.use_texture  = frag.use_texture;
		ent_d.fog_on       = cfg.enables[EN_FOG] & frag.apply_fog;
		ent_d.fog_num      = num_n[MAG_W-1:0];
		ent_d.fog_den      = den_n[MAG_W-1:0];
		ent_d.depth_pass   = !(cfg.enables[EN_DEPTH] && cfg.depth_mode &&
			(frag.frag_depth > frag.stored_depth));
		ent_d.frag_depth   = frag.frag_depth;
		ent_d.stored_color = frag.stored_color;

		// empty fog range: a step at the far distance
		priority if (den == 0) begin
			ent_d.fog_kind = (num > 0) ? FOGF_ONE : FOGF_ZERO;
		end else if (num_n <= 0) begin
			ent_d.fog_kind = FOGF_ZERO;
		end else if (num_n >= den_n) begin
			ent_d.fog_kind = FOGF_ONE;
		end else begin
			ent_d.fog_kind = FOGF_DIV;
		end
	end

	assign full       = (cnt_q == FQ_CNT_W'(FQ_DEPTH));
	assign wr_en      = push && !full;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FQ_CNT_W'(wr_en) - FQ_CNT_W'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= ent_d;
		end
	end

	`FCFB_ASSERT(a_fq_push_lands, (push && !full) |=> (cnt_q != '0))

endmodule

`default_nettype wire

FILE: rtl/fcfb_fogdiv.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Expects num < den; gives floor(num * 2^FOG_FRAC_BITS / den).
module fcfb_fogdiv import fcfb_pkg::*; (
	input  logic                     clk,
	input  logic [MAG_W-1:0]         num,
	input  logic [MAG_W-1:0]         den,
	output logic [FOG_FRAC_BITS-1:0] quo
);

	logic [MAG_W-1:0]         rem_s [DIV_STAGES];
	logic [MAG_W-1:0]         den_s [DIV_STAGES];
	logic [FOG_FRAC_BITS-1:0] quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [MAG_W-1:0]         rem_in;
		logic [MAG_W-1:0]         den_in;
		logic [FOG_FRAC_BITS-1:0] quo_in;
		logic [MAG_W:0]           dbl;
		logic                     ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign dbl = {rem_in, 1'b0};
		assign ge  = (dbl >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? MAG_W'(dbl - {1'b0, den_in}) : dbl[MAG_W-1:0];
			den_s[k] <= den_in;
			quo_s[k] <= {quo_in[FOG_FRAC_BITS-2:0], ge};
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/fcfb_back.sv
`default_nettype none
`include "assert_macros.svh"

module fcfb_back import fcfb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    head_valid,
	input  entry_t  head,
	output logic    take,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] color;
		logic                        pass;
		logic                        fog_on;
		fog_kind_t                   fog_kind;
		logic [DEPTH_W-1:0]          frag_depth;
		logic [COLOR_W-1:0]          stored_color;
	} side_t;

	// ---- output queue and credit ----
	result_t             omem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] owr_ptr_q;
	logic [OQ_PTR_W-1:0] ord_ptr_q;
	logic [OQ_CNT_W-1:0] ocnt_q;
	logic [OQ_CNT_W-1:0] rsv_q;   // items in flight plus items queued
	logic                opop;
	logic                wr_en;
	result_t             res_d;

	assign opop   = pop && !empty;
	assign empty  = (ocnt_q == '0);
	assign result = omem_q[ord_ptr_q];
	assign take   = head_valid && ((rsv_q != OQ_CNT_W'(OQ_DEPTH)) || opop);

	// ---- combine and alpha test ----
	side_t                       side_d;
	logic [NUM_CH-1:0][CH_W-1:0] vc;
	logic [NUM_CH-1:0][CH_W-1:0] tc;
	logic [CH_W:0]               q255;
	logic [CH_W:0]               sum9;
	logic [1:0]                  op;
	logic [CH_W-1:0]             cmb;

	always_comb begin
		vc = head.vertex_color;
		tc = head.texel_color;
		side_d.color = '0;
		q255 = '0;
		sum9 = '0;
		op   = '0;
		cmb  = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			op   = (i == NUM_CH - 1) ? cfg.combine_ops[3:2] : cfg.combine_ops[1:0];
			q255 = div255({1'b0, head.prod[i]});
			sum9 = {1'b0, vc[i]} + {1'b0, tc[i]};
			unique case (comb_op_t'(op))
				COMB_VERTEX:   cmb = vc[i];
				COMB_MODULATE: cmb = q255[CH_W-1:0];
				COMB_ADD:      cmb = sum9[CH_W] ? CH_MAX : sum9[CH_W-1:0];
				COMB_TEXEL:    cmb = tc[i];
				default:       cmb = vc[i];
			endcase
			side_d.color[i] = head.use_texture ? cmb : vc[i];
		end
		side_d.pass = head.depth_pass &&
			!(cfg.enables[EN_ALPHA] && (side_d.color[NUM_CH-1] < cfg.alpha_reference));
		side_d.fog_on       = head.fog_on;
		side_d.fog_kind     = head.fog_kind;
		side_d.frag_depth   = head.frag_depth;
		side_d.stored_color = head.stored_color;
	end

	// ---- fog factor divider, side data rides alongside ----
	logic [FOG_FRAC_BITS-1:0] quo;
	logic [DIV_STAGES-1:0]    vld_s;
	side_t                    side_s [DIV_STAGES];
	side_t                    side_dv;

	fcfb_fogdiv u_fogdiv (
		.clk (clk),
		.num (head.fog_num),
		.den (head.fog_den),
		.quo (quo)
	);

	assign side_dv = side_s[DIV_STAGES-1];

	// ---- fog ----
	logic [FOG_W-1:0]              fog_f;
	logic [FOG_W-1:0]              fog_inv;
	logic [NUM_CH-1:0][CH_W-1:0]   fog_col;
	logic [NUM_CH-1:0][CH_W-1:0]   fog_rgb;
	logic [CH_W+FOG_W-1:0]         fsum;

	always_comb begin
		unique case (side_dv.fog_kind)
			FOGF_ZERO: fog_f = '0;
			FOGF_ONE:  fog_f = FOG_ONE;
			FOGF_DIV:  fog_f = {1'b0, quo};
			default:   fog_f = '0;
		endcase
		fog_inv = FOG_ONE - fog_f;
		fog_rgb = {CH_W'(0), cfg.fog_rgb};
		fog_col = side_dv.color;
		fsum    = '0;
		if (side_dv.fog_on) begin
			for (int i = 0; i < NUM_CH - 1; i++) begin
				fsum = (CH_W+FOG_W)'(side_dv.color[i] * fog_f) +
					(CH_W+FOG_W)'(fog_rgb[i] * fog_inv);
				fog_col[i] = fsum[CH_W+FOG_FRAC_BITS-1:FOG_FRAC_BITS];
			end
		end
	end

	logic                        valid_s9;
	logic [NUM_CH-1:0][CH_W-1:0] col_s9;
	logic                        pass_s9;
	logic [DEPTH_W-1:0]          depth_s9;
	logic [COLOR_W-1:0]          stored_s9;

	// ---- blend products ----
	logic [NUM_CH-1:0][CH_W-1:0]   dst;
	logic [CH_W-1:0]               alpha;
	logic [CH_W-1:0]               src_f;
	logic [CH_W-1:0]               dst_f;
	logic [NUM_CH-1:0][2*CH_W:0]   bsum;

	always_comb begin
		dst   = stored_s9;
		alpha = col_s9[NUM_CH-1];
		src_f = cfg.blend_modes[0] ? CH_MAX : alpha;
		unique case (dst_factor_t'(cfg.blend_modes[2:1]))
			DST_INV_ALPHA: dst_f = CH_MAX - alpha;
			DST_ONE:       dst_f = CH_MAX;
			DST_ZERO:      dst_f = '0;
			DST_UNUSED:    dst_f = '0;
			default:       dst_f = '0;
		endcase
		for (int i = 0; i < NUM_CH; i++) begin
			bsum[i] = (2*CH_W+1)'(col_s9[i] * src_f) + (2*CH_W+1)'(dst[i] * dst_f);
		end
	end

	logic                        valid_s10;
	logic [NUM_CH-1:0][2*CH_W:0] bsum_s10;
	logic [NUM_CH-1:0][CH_W-1:0] col_s10;
	logic                        blend_s10;
	logic                        pass_s10;
	logic [DEPTH_W-1:0]          depth_s10;
	logic [COLOR_W-1:0]          stored_s10;

	// ---- final color, into the output queue ----
	logic [NUM_CH-1:0][CH_W-1:0] out_col;
	logic [CH_W:0]               bq;

	always_comb begin
		out_col = col_s10;
		bq      = '0;
		if (blend_s10) begin
			for (int i = 0; i < NUM_CH; i++) begin
				bq         = div255(bsum_s10[i]);
				out_col[i] = bq[CH_W] ? CH_MAX : bq[CH_W-1:0];
			end
		end
		res_d.color_out   = pass_s10 ? out_col : stored_s10;
		res_d.color_write = pass_s10;
		res_d.depth_out   = depth_s10;
		res_d.depth_write = pass_s10 & cfg.enables[EN_ZWRITE];
	end

	assign wr_en = valid_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q    <= '0;
			rsv_q     <= '0;
		end else begin
			vld_s     <= {vld_s[DIV_STAGES-2:0], take};
			valid_s9  <= vld_s[DIV_STAGES-1];
			valid_s10 <= valid_s9;
			if (wr_en) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (opop) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			ocnt_q <= ocnt_q + OQ_CNT_W'(wr_en) - OQ_CNT_W'(opop);
			rsv_q  <= rsv_q + OQ_CNT_W'(take) - OQ_CNT_W'(opop);
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_d;
		for (int k = 1; k < DIV_STAGES; k++) begin
			side_s[k] <= side_s[k-1];
		end
		col_s9     <= fog_col;
		pass_s9    <= side_dv.pass;
		depth_s9   <= side_dv.frag_depth;
		stored_s9  <= side_dv.stored_color;
		bsum_s10   <= bsum;
		col_s10    <= col_s9;
		blend_s10  <= cfg.enables[EN_BLEND];
		pass_s10   <= pass_s9;
		depth_s10  <= depth_s9;
		stored_s10 <= stored_s9;
		if (wr_en) begin
			omem_q[owr_ptr_q] <= res_d;
		end
	end

	`FCFB_ASSERT(a_rsv_bound, rsv_q <= OQ_CNT_W'(OQ_DEPTH))
	`FCFB_ASSERT(a_rsv_covers_queue, ocnt_q <= rsv_q)
	`FCFB_NEVER(a_oq_overflow, wr_en && (ocnt_q == OQ_CNT_W'(OQ_DEPTH)))

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import fcfb_pkg::*;

	localparam int FOG_UNIT    = 1 << FOG_FRAC_BITS;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;

	localparam logic [EN_W-1:0] M_BLEND  = EN_W'(1 << EN_BLEND);
	localparam logic [EN_W-1:0] M_ALPHA  = EN_W'(1 << EN_ALPHA);
	localparam logic [EN_W-1:0] M_DEPTH  = EN_W'(1 << EN_DEPTH);
	localparam logic [EN_W-1:0] M_FOG    = EN_W'(1 << EN_FOG);
	localparam logic [EN_W-1:0] M_ZWRITE = EN_W'(1 << EN_ZWRITE);

	typedef struct {
		cfg_t    cfg;
		frag_t   f;
		bit      typed;
		result_t want;
	} vector_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	frag_t                 frag = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	result_t               result;

	cfg_t      live_cfg;
	result_t   pending_pixels[$];
	vector_t   directed[$];
	int        mismatch_count = 0;
	int        stall_cycles = 0;
	bit        tx_burst = 1'b0;
	bit        rx_burst = 1'b0;

	fragment_combine_test_fog_blend_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.frag      (frag),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cfg_t mk_cfg(logic [EN_W-1:0] en, logic dm, logic [3:0] comb,
			logic [2:0] bm, logic [7:0] aref, logic [23:0] rgb,
			logic [DIST_W-1:0] fs, logic [DIST_W-1:0] fe);
		cfg_t c;
		c.enables         = en;
		c.depth_mode      = dm;
		c.combine_ops     = comb;
		c.blend_modes     = bm;
		c.alpha_reference = aref;
		c.fog_rgb         = rgb;
		c.fog_start       = fs;
		c.fog_end         = fe;
		return c;
	endfunction

	function automatic frag_t mk_frag(logic [31:0] vc, logic [31:0] tc, logic tex,
			logic fog, logic [DIST_W-1:0] fog_d, logic [DEPTH_W-1:0] fz,
			logic [31:0] sc, logic [DEPTH_W-1:0] sz);
		frag_t f;
		f.vertex_color = vc;
		f.texel_color  = tc;
		f.use_texture  = tex;
		f.apply_fog    = fog;
		f.fog_distance = fog_d;
		f.frag_depth   = fz;
		f.stored_color = sc;
		f.stored_depth = sz;
		return f;
	endfunction

	function automatic result_t mk_res(logic [31:0] color, logic cw, logic [DEPTH_W-1:0] z,
			logic zw);
		result_t r;
		r.color_out   = color;
		r.color_write = cw;
		r.depth_out   = z;
		r.depth_write = zw;
		return r;
	endfunction

	function automatic void add_vec(cfg_t c, frag_t f, bit typed, result_t want);
		vector_t v;
		v.cfg   = c;
		v.f     = f;
		v.typed = typed;
		v.want  = want;
		directed.push_back(v);
	endfunction

	// fog weight in units of 1/FOG_UNIT, truncated
	function automatic int fog_weight(logic signed [DIST_W-1:0] d, cfg_t c);
		longint far_v;
		longint num;
		longint den;
		far_v = $signed(c.fog_end);
		num   = far_v - longint'($signed(d));
		den   = far_v - longint'($signed(c.fog_start));
		if (den == 0)
			return (num > 0) ? FOG_UNIT : 0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0)
			return 0;
		if (num >= den)
			return FOG_UNIT;
		return int'((num * FOG_UNIT) / den);
	endfunction

	function automatic result_t shade_fragment(frag_t f, cfg_t c);
		result_t  r;
		int       col[4];
		int       v;
		int       t;
		int       w;
		int       s;
		int       sf;
		int       df;
		int       a;
		logic     pass;
		comb_op_t op;
		r = mk_res(f.stored_color, 1'b0, f.frag_depth, 1'b0);
		pass = !(c.enables[EN_DEPTH] && c.depth_mode && f.frag_depth > f.stored_depth);
		// channel 0..3 = blue, green, red, alpha
		for (int i = 0; i < NUM_CH; i++) begin
			v  = f.vertex_color[CH_W*i +: CH_W];
			t  = f.texel_color[CH_W*i +: CH_W];
			op = comb_op_t'((i == 3) ? c.combine_ops[3:2] : c.combine_ops[1:0]);
			if (!f.use_texture) begin
				col[i] = v;
			end else begin
				case (op)
					COMB_VERTEX:   col[i] = v;
					COMB_MODULATE: col[i] = (t * v) / 255;
					COMB_ADD:      col[i] = (t + v > 255) ? 255 : t + v;
					default:       col[i] = t;
				endcase
			end
		end
		if (pass && c.enables[EN_ALPHA] && col[3] < int'(c.alpha_reference))
			pass = 1'b0;
		if (!pass)
			return r;
		if (c.enables[EN_FOG] && f.apply_fog) begin
			w = fog_weight(f.fog_distance, c);
			for (int i = 0; i < 3; i++)
				col[i] = (col[i] * w + int'(c.fog_rgb[CH_W*i +: CH_W]) * (FOG_UNIT - w))
					>> FOG_FRAC_BITS;
		end
		a = col[3];
		for (int i = 0; i < NUM_CH; i++) begin
			if (c.enables[EN_BLEND]) begin
				sf = c.blend_modes[0] ? 255 : a;
				case (dst_factor_t'(c.blend_modes[2:1]))
					DST_INV_ALPHA: df = 255 - a;
					DST_ONE:       df = 255;
					default:       df = 0;
				endcase
				s = (col[i] * sf + int'(f.stored_color[CH_W*i +: CH_W]) * df) / 255;
				col[i] = (s > 255) ? 255 : s;
			end
			r.color_out[CH_W*i +: CH_W] = col[i][CH_W-1:0];
		end
		r.color_write = 1'b1;
		r.depth_write = c.enables[EN_ZWRITE];
		return r;
	endfunction

	function automatic cfg_t rand_setting(int phase);
		cfg_t c;
		c.enables         = EN_W'($urandom);
		c.depth_mode      = 1'($urandom);
		c.combine_ops     = 4'($urandom);
		c.blend_modes     = 3'($urandom);
		c.alpha_reference = $urandom_range(0, 1) ? 8'($urandom_range(0, 48)) : 8'($urandom);
		c.fog_rgb         = 24'($urandom);
		c.fog_start       = DIST_W'($urandom);
		case ($urandom_range(0, 3))
			0: c.fog_end = DIST_W'($urandom);
			1: c.fog_end = $urandom_range(0, 1) ? c.fog_start + DIST_W'($urandom_range(1, 64))
				: c.fog_start - DIST_W'($urandom_range(1, 64));
			2: c.fog_end = c.fog_start;
			default: c.fog_end = c.fog_start + DIST_W'($urandom_range(1, 4096));
		endcase
		if (phase == 0) begin
			c = mk_cfg('0, 1'b0, '0, '0, '0, '0, 24'h800000, 24'h800000);
		end else if (phase == 1) begin
			c = mk_cfg('1, 1'b1, '1, '1, '1, '1, 24'h7FFFFF, 24'h7FFFFF);
		end else if (phase == 2) begin
			c.enables   = '1;
			c.fog_start = 24'h800000;
			c.fog_end   = 24'h7FFFFF;
		end
		return c;
	endfunction

	function automatic frag_t rand_frag(cfg_t c);
		frag_t  f;
		longint lo;
		longint hi;
		longint span;
		f.vertex_color = $urandom;
		f.texel_color  = $urandom;
		f.use_texture  = ($urandom_range(0, 7) != 0);
		f.apply_fog    = ($urandom_range(0, 7) != 0);
		f.stored_color = $urandom;
		f.stored_depth = DEPTH_W'($urandom);
		f.frag_depth   = ($urandom_range(0, 3) == 0) ? f.stored_depth : DEPTH_W'($urandom);
		lo = $signed(c.fog_start);
		hi = $signed(c.fog_end);
		if (lo > hi) begin
			span = lo;
			lo   = hi;
			hi   = span;
		end
		span = hi - lo;
		// mostly around the fog range, a bit past both ends
		if ($urandom_range(0, 9) == 0)
			f.fog_distance = DIST_W'($urandom);
		else
			f.fog_distance = DIST_W'(lo - span / 8 - 2
				+ longint'($urandom_range(0, 32'(span + span / 4 + 4))));
		return f;
	endfunction

	task automatic put_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// registers only change with nothing in flight
	task automatic load_cfg(cfg_t c);
		push <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		put_reg(CFG_ENABLES,     CFG_DATA_W'(c.enables));
		put_reg(CFG_DEPTH_MODE,  CFG_DATA_W'(c.depth_mode));
		put_reg(CFG_COMBINE_OPS, CFG_DATA_W'(c.combine_ops));
		put_reg(CFG_BLEND_MODES, CFG_DATA_W'(c.blend_modes));
		put_reg(CFG_ALPHA_REF,   CFG_DATA_W'(c.alpha_reference));
		put_reg(CFG_FOG_RGB,     CFG_DATA_W'(c.fog_rgb));
		put_reg(CFG_FOG_START,   CFG_DATA_W'(c.fog_start));
		put_reg(CFG_FOG_END,     CFG_DATA_W'(c.fog_end));
		cfg_we   <= 1'b0;
		live_cfg = c;
	endtask

	// push stays high after acceptance; the next item or a gap decides
	task automatic send_frag(frag_t f, bit typed, result_t want);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		frag <= f;
		do
			@(posedge clk);
		while (full);
		pending_pixels.push_back(typed ? want : shade_fragment(f, live_cfg));
	endtask

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = rx_burst ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
		end
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected item, expected none, got %h", $time, result);
				mismatch_count++;
			end else begin
				exp_r = pending_pixels.pop_front();
				if (result.color_out !== exp_r.color_out) begin
					$display("%0t: color_out expected %h got %h", $time,
						exp_r.color_out, result.color_out);
					mismatch_count++;
				end
				if (result.color_write !== exp_r.color_write) begin
					$display("%0t: color_write expected %b got %b", $time,
						exp_r.color_write, result.color_write);
					mismatch_count++;
				end
				if (result.depth_out !== exp_r.depth_out) begin
					$display("%0t: depth_out expected %h got %h", $time,
						exp_r.depth_out, result.depth_out);
					mismatch_count++;
				end
				if (result.depth_write !== exp_r.depth_write) begin
					$display("%0t: depth_write expected %b got %b", $time,
						exp_r.depth_write, result.depth_write);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		cfg_t cfg_rst;
		cfg_t cfg_depth;
		cfg_t cfg_depth_any;
		cfg_t cfg_mod_add;
		cfg_t cfg_texel;
		cfg_t cfg_alpha;
		cfg_t cfg_fog;
		cfg_t cfg_fog_eq;
		cfg_t cfg_fog_rev;
		cfg_t cfg_blend;
		cfg_t cfg_blend_one;
		cfg_t cfg_blend_unused;
		cfg_t cfg_blend_zero;
		logic [2:0] bm_rst;
		logic [3:0] cm_rst;

		bm_rst  = {DST_INV_ALPHA, 1'b0};
		cm_rst  = {COMB_VERTEX, COMB_VERTEX};
		cfg_rst = mk_cfg('0, 1'b0, cm_rst, bm_rst, '0, '0, '0, FOG_END_RST);
		cfg_depth        = mk_cfg(M_DEPTH | M_ZWRITE, 1'b1, cm_rst, bm_rst, '0, '0, '0,
			FOG_END_RST);
		cfg_depth_any    = mk_cfg(M_DEPTH | M_ZWRITE, 1'b0, cm_rst, bm_rst, '0, '0, '0,
			FOG_END_RST);
		cfg_mod_add      = mk_cfg('0, 1'b0, {COMB_ADD, COMB_MODULATE}, bm_rst, '0, '0, '0,
			FOG_END_RST);
		cfg_texel        = mk_cfg('0, 1'b0, {COMB_TEXEL, COMB_TEXEL}, bm_rst, '0, '0, '0,
			FOG_END_RST);
		cfg_alpha        = mk_cfg(M_ALPHA, 1'b0, cm_rst, bm_rst, 8'h80, '0, '0, FOG_END_RST);
		cfg_fog          = mk_cfg(M_FOG, 1'b0, cm_rst, bm_rst, '0, 24'h102030, '0, 24'h000100);
		cfg_fog_eq       = mk_cfg(M_FOG, 1'b0, cm_rst, bm_rst, '0, 24'h102030, 24'h000100,
			24'h000100);
		cfg_fog_rev      = mk_cfg(M_FOG, 1'b0, cm_rst, bm_rst, '0, 24'hF0E0D0, 24'h7FFFFF,
			24'h800000);
		cfg_blend        = mk_cfg(M_BLEND, 1'b0, cm_rst, {DST_INV_ALPHA, 1'b0}, '0, '0, '0,
			FOG_END_RST);
		cfg_blend_one    = mk_cfg(M_BLEND, 1'b0, cm_rst, {DST_ONE, 1'b1}, '0, '0, '0,
			FOG_END_RST);
		cfg_blend_unused = mk_cfg(M_BLEND, 1'b0, cm_rst, {DST_UNUSED, 1'b0}, '0, '0, '0,
			FOG_END_RST);
		cfg_blend_zero   = mk_cfg(M_BLEND, 1'b0, cm_rst, {DST_ZERO, 1'b1}, '0, '0, '0,
			FOG_END_RST);

		// reset settings pass the vertex color straight through
		add_vec(cfg_rst, mk_frag('0, '0, 1'b0, 1'b0, '0, '0, '0, '0), 1'b1,
			mk_res('0, 1'b1, '0, 1'b0));
		add_vec(cfg_rst, mk_frag('1, '1, 1'b1, 1'b1, 24'h7FFFFF, '1, '1, '1), 1'b1,
			mk_res(32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 1'b0));
		add_vec(cfg_rst, mk_frag(32'h12345678, 32'h87654321, 1'b1, 1'b1, 24'h800000,
			24'h00AA00, 32'h0, 24'h0), 1'b1, mk_res(32'h12345678, 1'b1, 24'h00AA00, 1'b0));
		// depth test
		add_vec(cfg_depth, mk_frag(32'h01234567, '0, 1'b0, 1'b0, '0, 24'h000101,
			32'h11223344, 24'h000100), 1'b1, mk_res(32'h11223344, 1'b0, 24'h000101, 1'b0));
		add_vec(cfg_depth, mk_frag(32'h0A0B0C0D, '0, 1'b0, 1'b0, '0, 24'hABCDEF,
			32'h11223344, 24'hABCDEF), 1'b1, mk_res(32'h0A0B0C0D, 1'b1, 24'hABCDEF, 1'b1));
		add_vec(cfg_depth, mk_frag(32'h01020304, '0, 1'b0, 1'b0, '0, 24'h000000,
			32'h11223344, 24'hFFFFFF), 1'b1, mk_res(32'h01020304, 1'b1, 24'h000000, 1'b1));
		// depth mode 0: test enabled but always passes
		add_vec(cfg_depth_any, mk_frag(32'h55AA55AA, '0, 1'b0, 1'b0, '0, 24'hFFFFFF,
			32'h11223344, 24'h000000), 1'b1, mk_res(32'h55AA55AA, 1'b1, 24'hFFFFFF, 1'b1));
		// combine
		add_vec(cfg_mod_add, mk_frag(32'h80FF4020, 32'h90FF8010, 1'b1, 1'b0, '0, 24'h1,
			32'h0, 24'h0), 1'b0, '0);
		add_vec(cfg_mod_add, mk_frag('1, '1, 1'b1, 1'b0, '0, 24'h000010, 32'h0, 24'h0), 1'b1,
			mk_res(32'hFFFFFFFF, 1'b1, 24'h000010, 1'b0));
		add_vec(cfg_mod_add, mk_frag(32'h33445566, '1, 1'b0, 1'b0, '0, 24'h123456, 32'h0,
			24'h0), 1'b1, mk_res(32'h33445566, 1'b1, 24'h123456, 1'b0));
		add_vec(cfg_texel, mk_frag(32'h01010101, 32'h5A6B7C8D, 1'b1, 1'b0, '0, 24'h7, 32'h0,
			24'h0), 1'b1, mk_res(32'h5A6B7C8D, 1'b1, 24'h7, 1'b0));
		// alpha test on either side of the reference
		add_vec(cfg_alpha, mk_frag(32'h7F112233, '0, 1'b0, 1'b0, '0, 24'h20, 32'h9ABCDEF0,
			24'h0), 1'b1, mk_res(32'h9ABCDEF0, 1'b0, 24'h20, 1'b0));
		add_vec(cfg_alpha, mk_frag(32'h80112233, '0, 1'b0, 1'b0, '0, 24'h20, 32'h9ABCDEF0,
			24'h0), 1'b1, mk_res(32'h80112233, 1'b1, 24'h20, 1'b0));
		// fog: inside, before start, past end, fog off for this fragment
		add_vec(cfg_fog, mk_frag(32'hAABBCCDD, '0, 1'b0, 1'b1, 24'h000080, 24'h3, '0, '0),
			1'b0, '0);
		add_vec(cfg_fog, mk_frag(32'hAABBCCDD, '0, 1'b0, 1'b1, 24'hFFFF00, 24'h3, '0, '0),
			1'b1, mk_res(32'hAABBCCDD, 1'b1, 24'h3, 1'b0));
		add_vec(cfg_fog, mk_frag(32'hAABBCCDD, '0, 1'b0, 1'b1, 24'h000200, 24'h3, '0, '0),
			1'b1, mk_res(32'hAA102030, 1'b1, 24'h3, 1'b0));
		add_vec(cfg_fog, mk_frag(32'hAABBCCDD, '0, 1'b0, 1'b0, 24'h000200, 24'h3, '0, '0),
			1'b1, mk_res(32'hAABBCCDD, 1'b1, 24'h3, 1'b0));
		// empty fog range: full weight just below the end, none at it
		add_vec(cfg_fog_eq, mk_frag(32'hAABBCCDD, '0, 1'b0, 1'b1, 24'h0000FF, 24'h3, '0, '0),
			1'b1, mk_res(32'hAABBCCDD, 1'b1, 24'h3, 1'b0));
		add_vec(cfg_fog_eq, mk_frag(32'hAABBCCDD, '0, 1'b0, 1'b1, 24'h000100, 24'h3, '0, '0),
			1'b1, mk_res(32'hAA102030, 1'b1, 24'h3, 1'b0));
		// reversed range at the extremes
		add_vec(cfg_fog_rev, mk_frag(32'h11335577, '0, 1'b0, 1'b1, 24'h000000, 24'h3, '0, '0),
			1'b0, '0);
		add_vec(cfg_fog_rev, mk_frag(32'h11335577, '0, 1'b0, 1'b1, 24'h800000, 24'h3, '0, '0),
			1'b0, '0);
		// blend factors, including the unused destination code
		add_vec(cfg_blend, mk_frag(32'h80FF0000, '0, 1'b0, 1'b0, '0, 24'h3, 32'h00FF00FF,
			'0), 1'b0, '0);
		add_vec(cfg_blend_one, mk_frag('1, '0, 1'b0, 1'b0, '0, 24'h3, '1, '0), 1'b1,
			mk_res(32'hFFFFFFFF, 1'b1, 24'h3, 1'b0));
		add_vec(cfg_blend_unused, mk_frag(32'h40A0B0C0, '0, 1'b0, 1'b0, '0, 24'h3,
			32'h12345678, '0), 1'b0, '0);
		add_vec(cfg_blend_zero, mk_frag(32'h40A0B0C0, '0, 1'b0, 1'b0, '0, 24'h3,
			32'h12345678, '0), 1'b1, mk_res(32'h40A0B0C0, 1'b1, 24'h3, 1'b0));

		live_cfg = cfg_rst;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			if (directed[k].cfg != live_cfg)
				load_cfg(directed[k].cfg);
			send_frag(directed[k].f, directed[k].typed, directed[k].want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			load_cfg(rand_setting(phase));
			tx_burst = (phase % 4 == 1) || (phase % 4 == 3);
			rx_burst = (phase % 4 == 2) || (phase % 4 == 3);
			repeat (PHASE_ITEMS)
				send_frag(rand_frag(live_cfg), 1'b0, '0);
		end

		push <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: fragment_combine_test_fog_blend_unit.f
+incdir+rtl
rtl/fcfb_pkg.sv
rtl/fcfb_front.sv
rtl/fcfb_fogdiv.sv
rtl/fcfb_back.sv
rtl/fragment_combine_test_fog_blend_unit.sv
tb/testbench.sv
